// ===== src/conv3x3_edge_threshold_defines.svh =====
// Assertion macros for the 3x3 edge detector.
// Included by the top level, which checks its own logic; needs i_clk and i_rst_n in scope.
`ifndef CONV3X3_EDGE_THRESHOLD_DEFINES_SVH
`define CONV3X3_EDGE_THRESHOLD_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define C3E_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define C3E_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/c3e_pkg.sv =====
// Shared types and constants of the 3x3 edge detector.
// No dependencies; used by c3e_line_store, c3e_kernel and conv3x3_edge_threshold.
package c3e_pkg;

    localparam int PIXEL_BITS      = 8;
    localparam int MAX_WIDTH_DEF   = 1024;
    localparam int MAX_HEIGHT_DEF  = 4096;

    localparam int CFG_DATA_BITS   = 24;
    localparam int CFG_INDEX_BITS  = 3;
    localparam int WIDTH_REG_BITS  = 11;
    localparam int HEIGHT_REG_BITS = 13;

    localparam logic [PIXEL_BITS-1:0]      THRESHOLD_RST = 8'd30;
    localparam logic [WIDTH_REG_BITS-1:0]  WIDTH_RST     = 11'd640;
    localparam logic [HEIGHT_REG_BITS-1:0] HEIGHT_RST    = 13'd480;
    localparam logic [PIXEL_BITS-1:0]      PIXEL_MAX     = 8'hff;

    // Products are 8-bit signed coefficient times 8-bit pixel; nine of them summed.
    localparam int PROD_BITS = 17;
    localparam int SUM_BITS  = 20;

    // Bit positions of the pending-result mask, in output order.
    localparam int RES_CENTER  = 0;  // centre one column back, row above
    localparam int RES_ROW_END = 1;  // last centre of the row above
    localparam int RES_BOTTOM  = 2;  // centre on the bottom row
    localparam int RES_CORNER  = 3;  // bottom-right centre of the frame
    localparam int RES_KINDS   = 4;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_COEF_TOP    = 3'd0,
        CFG_COEF_MIDDLE = 3'd1,
        CFG_COEF_BOTTOM = 3'd2,
        CFG_THRESHOLD   = 3'd3,
        CFG_WIDTH       = 3'd4,
        CFG_HEIGHT      = 3'd5,
        CFG_BINARY_MODE = 3'd6
    } t_cfg_idx;

    // Window indexed [row][column]; row 2 is the newest row, column 2 the newest column.
    typedef logic [2:0][2:0][PIXEL_BITS-1:0] t_window;

    typedef logic [2:0][CFG_DATA_BITS-1:0] t_coef_set;

    // Window shift for one result: taps that fall past the window edge read zero.
    typedef struct packed {
        logic dr;
        logic dc;
    } t_tap_sel;

    typedef struct packed {
        logic run_last;
        logic frame_done;
    } t_res_tag;

endpackage

// ===== src/c3e_line_store.sv =====
// Two line stores of the edge detector: previous row (a) and the row before it (b).
// Reads are registered; a write moves the held row-a data into row b.
// Depends on c3e_pkg.
module c3e_line_store import c3e_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_rd_addr,
    input  logic                         i_wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_wr_addr,
    input  logic [PIXEL_BITS-1:0]        i_wr_pixel,
    output logic [PIXEL_BITS-1:0]        o_rd_a,
    output logic [PIXEL_BITS-1:0]        o_rd_b
);

    logic [PIXEL_BITS-1:0] r_mem_a [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] r_mem_b [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] r_rd_a;
    logic [PIXEL_BITS-1:0] r_rd_b;

    // Read data holds until the next read, so a stalled pixel keeps its column.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_a <= r_mem_a[i_rd_addr];
            r_rd_b <= r_mem_b[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem_a[i_wr_addr] <= i_wr_pixel;
            r_mem_b[i_wr_addr] <= r_rd_a;
        end
    end

    assign o_rd_a = r_rd_a;
    assign o_rd_b = r_rd_b;

endmodule

// ===== src/c3e_kernel.sv =====
// Multiply-accumulate pipeline of the edge detector: nine products, then sum and
// threshold or saturation into the output register. Depends on c3e_pkg.
module c3e_kernel import c3e_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_issue,
    input  t_window               i_window,
    input  t_tap_sel              i_sel,
    input  t_res_tag              i_tag,
    input  t_coef_set             i_coef,
    input  logic [PIXEL_BITS-1:0] i_threshold,
    input  logic                  i_binary_mode,
    output logic                  o_take,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [PIXEL_BITS-1:0] o_pixel,
    output t_res_tag              o_tag
);

    logic                        r_s2_valid;
    logic signed [PROD_BITS-1:0] r_prod [9];
    t_res_tag                    r_s2_tag;
    logic                        r_valid;
    logic [PIXEL_BITS-1:0]       r_pixel;
    t_res_tag                    r_tag;

    logic signed [PROD_BITS-1:0] n_prod [9];
    logic signed [SUM_BITS-1:0]  sum;
    logic [PIXEL_BITS-1:0]       n_pixel;
    logic                        out_en;

    assign out_en = !r_valid || i_ready;
    assign o_take = !r_s2_valid || out_en;

    // Tap (kr, kc) reads window (kr+dr, kc+dc); past the edge it is zero padding.
    always_comb begin
        logic [PIXEL_BITS-1:0] tap;
        logic [PIXEL_BITS-1:0] coef;
        int                    wr;
        int                    wc;
        for (int kr = 0; kr < 3; kr++) begin
            for (int kc = 0; kc < 3; kc++) begin
                wr   = kr + int'(i_sel.dr);
                wc   = kc + int'(i_sel.dc);
                tap  = '0;
                if (wr < 3 && wc < 3) begin
                    tap = i_window[wr][wc];
                end
                coef = i_coef[kr][PIXEL_BITS*kc +: PIXEL_BITS];
                n_prod[3*kr+kc] = PROD_BITS'($signed(coef)) * PROD_BITS'($signed({1'b0, tap}));
            end
        end
    end

    always_comb begin
        sum = '0;
        for (int k = 0; k < 9; k++) begin
            sum = sum + SUM_BITS'(r_prod[k]);
        end
        if (i_binary_mode) begin
            n_pixel = (sum > $signed({{(SUM_BITS-PIXEL_BITS){1'b0}}, i_threshold}))
                      ? PIXEL_MAX : '0;
        end else if (sum < 0) begin
            n_pixel = '0;
        end else if (sum > $signed(SUM_BITS'(PIXEL_MAX))) begin
            n_pixel = PIXEL_MAX;
        end else begin
            n_pixel = sum[PIXEL_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            if (o_take) begin
                r_s2_valid <= i_issue;
            end
            if (out_en) begin
                r_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_issue) begin
            r_prod   <= n_prod;
            r_s2_tag <= i_tag;
        end
        if (out_en && r_s2_valid) begin
            r_pixel <= n_pixel;
            r_tag   <= r_s2_tag;
        end
    end

    assign o_valid = r_valid;
    assign o_pixel = r_pixel;
    assign o_tag   = r_tag;

endmodule

// ===== src/conv3x3_edge_threshold.sv =====
// 3x3 convolution edge detector with threshold: top level.
// A pixel passes stage 1, the window, the product and output registers. Throughput: 1 pixel
// per cycle without output stalls; the single MAC pipeline issues one result per cycle, so a
// pixel with two results (row end, bottom row) or four (frame's last) holds the input longer.
// Reset (synchronous, active low) restores the register defaults and clears the counters
// and window; the line stores need no clearing pass and are written before they are read.
module conv3x3_edge_threshold import c3e_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Configuration writes
    input  logic                      i_cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_wdata,
    // Pixel input
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [PIXEL_BITS-1:0]     i_pixel,
    // Result output
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [PIXEL_BITS-1:0]     o_result_pixel,
    output logic                      o_run_last,
    output logic                      o_frame_done
);

`include "conv3x3_edge_threshold_defines.svh"

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    // Width of the geometry compares: wide enough for the register and for the maximum.
    localparam int WW = (CW + 1 > WIDTH_REG_BITS) ? CW + 1 : WIDTH_REG_BITS;
    localparam int HW = (RW + 1 > HEIGHT_REG_BITS) ? RW + 1 : HEIGHT_REG_BITS;

    // Configuration registers.
    t_coef_set                  r_coef;
    logic [PIXEL_BITS-1:0]      r_threshold;
    logic [WIDTH_REG_BITS-1:0]  r_width;
    logic [HEIGHT_REG_BITS-1:0] r_height;
    logic                       r_binary_mode;

    // Raster position of the next pixel.
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;

    // Stage 1: the accepted pixel while its line store read completes.
    logic                  r_s1_valid;
    logic [PIXEL_BITS-1:0] r_s1_px;
    logic [CW-1:0]         r_s1_addr;
    logic                  r_s1_first_col;
    logic                  r_s1_row_ge1;
    logic                  r_s1_row_ge2;
    logic [RES_KINDS-1:0]  r_s1_mask;

    // Window and the results still to be issued from it.
    t_window              r_win;
    logic [RES_KINDS-1:0] r_pend;

    logic [WW-1:0]         w_eff;
    logic [HW-1:0]         h_eff;
    logic                  last_col;
    logic                  last_row;
    logic                  in_accept;
    logic [RES_KINDS-1:0]  n_mask;
    logic [RES_KINDS-1:0]  sel;
    logic [RES_KINDS-1:0]  pend_after;
    logic                  issue;
    logic                  s1_fire;
    logic                  kern_take;
    t_tap_sel              tap_sel;
    t_res_tag              issue_tag;
    t_res_tag              out_tag;
    t_window               n_win;
    logic [PIXEL_BITS-1:0] rd_a;
    logic [PIXEL_BITS-1:0] rd_b;

    //--------------------------------------------------------------------------
    // Configuration. Writes must arrive only while idle; the block itself does not enforce it.
    //--------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef        <= '0;
            r_threshold   <= THRESHOLD_RST;
            r_width       <= WIDTH_RST;
            r_height      <= HEIGHT_RST;
            r_binary_mode <= 1'b1;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_COEF_TOP:    r_coef[0]     <= i_cfg_wdata;
                CFG_COEF_MIDDLE: r_coef[1]     <= i_cfg_wdata;
                CFG_COEF_BOTTOM: r_coef[2]     <= i_cfg_wdata;
                CFG_THRESHOLD:   r_threshold   <= i_cfg_wdata[PIXEL_BITS-1:0];
                CFG_WIDTH:       r_width       <= i_cfg_wdata[WIDTH_REG_BITS-1:0];
                CFG_HEIGHT:      r_height      <= i_cfg_wdata[HEIGHT_REG_BITS-1:0];
                CFG_BINARY_MODE: r_binary_mode <= i_cfg_wdata[0];
                default:         ;
            endcase
        end
    end

    //--------------------------------------------------------------------------
    // Geometry. Width and height are clamped to 2..MAX; a count at or past the
    // last column or row counts as the last one, so a shrink mid-frame wraps.
    //--------------------------------------------------------------------------
    always_comb begin
        if (WW'(r_width) < WW'(2)) begin
            w_eff = WW'(2);
        end else if (WW'(r_width) > WW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_width);
        end
        if (HW'(r_height) < HW'(2)) begin
            h_eff = HW'(2);
        end else if (HW'(r_height) > HW'(MAX_HEIGHT)) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(r_height);
        end
    end

    assign last_col  = (WW'(r_col) + WW'(1)) >= w_eff;
    assign last_row  = (HW'(r_row) + HW'(1)) >= h_eff;
    assign in_accept = i_valid && o_ready;

    // Results this pixel causes, in output order. Row 0 produces none except
    // through the bottom-row terms, which cannot apply since height is at least 2.
    always_comb begin
        n_mask             = '0;
        n_mask[RES_CENTER]  = (r_row != '0) && (r_col != '0);
        n_mask[RES_ROW_END] = (r_row != '0) && last_col;
        n_mask[RES_BOTTOM]  = last_row && (r_col != '0);
        n_mask[RES_CORNER]  = last_row && last_col;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_accept) begin
            if (last_col) begin
                r_col <= '0;
                r_row <= last_row ? '0 : RW'(r_row + RW'(1));
            end else begin
                r_col <= CW'(r_col + CW'(1));
            end
        end
    end

    //--------------------------------------------------------------------------
    // Line stores. The read is issued on the pixel transfer; the write-back of
    // the same column happens when the pixel leaves stage 1. Consecutive pixels
    // always address different columns, so a read never meets a pending write.
    //--------------------------------------------------------------------------
    c3e_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk      (i_clk),
        .i_rd_en    (in_accept),
        .i_rd_addr  (r_col),
        .i_wr_en    (s1_fire),
        .i_wr_addr  (r_s1_addr),
        .i_wr_pixel (r_s1_px),
        .o_rd_a     (rd_a),
        .o_rd_b     (rd_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_ready) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_px        <= i_pixel;
            r_s1_addr      <= r_col;
            r_s1_first_col <= (r_col == '0);
            r_s1_row_ge1   <= (r_row != '0);
            r_s1_row_ge2   <= (r_row > RW'(1));
            r_s1_mask      <= n_mask;
        end
    end

    //--------------------------------------------------------------------------
    // Window update. The window starts from zero at the first column, shifts one
    // column left and takes the new column: two rows back, one row back, and the
    // incoming pixel, with rows above the frame read as zero.
    //--------------------------------------------------------------------------
    always_comb begin
        t_window base;
        base = r_s1_first_col ? '0 : r_win;
        for (int k = 0; k < 3; k++) begin
            n_win[k][0] = base[k][1];
            n_win[k][1] = base[k][2];
        end
        n_win[0][2] = r_s1_row_ge2 ? rd_b : '0;
        n_win[1][2] = r_s1_row_ge1 ? rd_a : '0;
        n_win[2][2] = r_s1_px;
    end

    //--------------------------------------------------------------------------
    // Result sequencing. One pending result is issued into the MAC pipeline per cycle
    // while it can take one, lowest bit first. The next pixel may replace the window in
    // the same cycle as the last issue, since the issue reads the current window.
    //--------------------------------------------------------------------------
    assign sel        = r_pend & RES_KINDS'(~r_pend + RES_KINDS'(1));
    assign pend_after = r_pend & ~sel;
    assign issue      = (r_pend != '0) && kern_take;
    assign s1_fire    = r_s1_valid && ((r_pend == '0) || (issue && (pend_after == '0)));
    assign o_ready    = !r_s1_valid || s1_fire;

    assign tap_sel.dr           = sel[RES_BOTTOM] || sel[RES_CORNER];
    assign tap_sel.dc           = sel[RES_ROW_END] || sel[RES_CORNER];
    assign issue_tag.run_last   = (pend_after == '0);
    assign issue_tag.frame_done = sel[RES_CORNER];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win  <= '0;
            r_pend <= '0;
        end else if (s1_fire) begin
            r_win  <= n_win;
            r_pend <= r_s1_mask;
        end else if (issue) begin
            r_pend <= pend_after;
        end
    end

    //--------------------------------------------------------------------------
    // MAC pipeline and output register.
    //--------------------------------------------------------------------------
    c3e_kernel u_kernel (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_issue       (issue),
        .i_window      (r_win),
        .i_sel         (tap_sel),
        .i_tag         (issue_tag),
        .i_coef        (r_coef),
        .i_threshold   (r_threshold),
        .i_binary_mode (r_binary_mode),
        .o_take        (kern_take),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_pixel       (o_result_pixel),
        .o_tag         (out_tag)
    );

    assign o_run_last   = out_tag.run_last;
    assign o_frame_done = out_tag.frame_done;

    //--------------------------------------------------------------------------
    // Assertions
    //--------------------------------------------------------------------------
    `C3E_ASSERT_NEXT(a_transfer_fills_s1, in_accept, r_s1_valid, "accepted pixel lost before stage 1")
    `C3E_ASSERT_IMPL(a_stall_has_cause, r_s1_valid && !o_ready, r_pend != '0, "input stalled with no pending result")
    `C3E_ASSERT_IMPL(a_corner_ends_run, issue && sel[RES_CORNER], pend_after == '0, "frame corner result is not the last of its run")
    `C3E_ASSERT_IMPL(a_frame_done_last, o_valid && o_frame_done, o_run_last, "frame_done without run_last")

endmodule
